>>> design/stcb_pkg.sv
`timescale 1ns / 1ps

package stcb_pkg;

	localparam int TABLE_DEPTH_DEF = 256;

	localparam logic [23:0] SPC_MAX   = 24'hFF_FFFF;
	localparam logic [23:0] CHUNK_MAX = 24'hFF_FFFF;

	typedef enum logic [1:0] {
		ST_APPEND = 2'd0,
		ST_NEW    = 2'd1,
		ST_MERGE  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_CALC = 1'b1
	} fsm_t;

	typedef struct packed {
		logic [15:0] desc_index;
		logic        force_new_chunk;
		logic [15:0] sample_count;
		logic [47:0] byte_offset;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [47:0] chunk_offset;
		logic [23:0] chunk_number;
		logic [8:0]  entry_count;
		logic [23:0] entry_samples;
	} result_t;

	typedef struct packed {
		logic [23:0] first_chunk;
		logic [15:0] desc_index;
		logic [23:0] spc;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic        wr_en;
		logic        new_chunk;
		entry_t      wr_entry;
		logic [23:0] chunk_number;
		logic [23:0] entry_samples;
	} upd_t;

endpackage

>>> design/stcb_entry_mem.sv
`timescale 1ns / 1ps

module stcb_entry_mem #(
	parameter int DEPTH = stcb_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  stcb_pkg::entry_t wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output stcb_pkg::entry_t rd_data_a,
	output stcb_pkg::entry_t rd_data_b
);
	import stcb_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_a_q;
	entry_t rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_a_q <= mem_q[rd_addr_a];
			rd_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

>>> design/stcb_update.sv
`timescale 1ns / 1ps

module stcb_update #(
	parameter int DEPTH = stcb_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  stcb_pkg::item_t  item,
	input  logic [15:0]      max_spc,
	input  logic [CW-1:0]    used,
	input  logic [23:0]      chunks,
	input  stcb_pkg::entry_t last,
	input  stcb_pkg::entry_t prev,
	output stcb_pkg::upd_t   upd,
	output logic [CW-1:0]    used_next,
	output logic [AW-1:0]    wr_addr
);
	import stcb_pkg::*;

	logic          empty;
	logic          fresh;
	logic          merge;
	logic          full;
	logic [CW-1:0] used_m1;
	logic [CW-1:0] kept;
	logic [24:0]   spc_sum;
	logic [23:0]   spc_sat;
	logic [23:0]   chunk_inc;

	always_comb begin
		empty     = (used == '0);
		used_m1   = used - CW'(1);
		fresh     = item.force_new_chunk || empty || (item.desc_index != last.desc_index)
			|| ((max_spc != 16'd0) && (last.spc >= {8'd0, max_spc}));
		merge     = (used > CW'(1)) && (prev.desc_index == last.desc_index)
			&& (prev.spc == last.spc);
		kept      = merge ? used_m1 : used;
		full      = (kept >= CW'(DEPTH)) || (chunks == CHUNK_MAX);
		spc_sum   = {1'b0, last.spc} + {9'd0, item.sample_count};
		spc_sat   = spc_sum[24] ? SPC_MAX : spc_sum[23:0];
		chunk_inc = chunks + 24'd1;

		upd       = '0;
		used_next = used;
		wr_addr   = used_m1[AW-1:0];

		if (!fresh) begin
			upd.status        = ST_APPEND;
			upd.wr_en         = 1'b1;
			upd.wr_entry      = '{first_chunk: last.first_chunk,
				desc_index: last.desc_index, spc: spc_sat};
			upd.chunk_number  = chunks;
			upd.entry_samples = spc_sat;
		end else if (full) begin
			upd.status        = ST_FULL;
			upd.chunk_number  = chunks;
			upd.entry_samples = empty ? 24'd0 : last.spc;
		end else begin
			upd.status        = merge ? ST_MERGE : ST_NEW;
			upd.wr_en         = 1'b1;
			upd.new_chunk     = 1'b1;
			upd.wr_entry      = '{first_chunk: chunk_inc, desc_index: item.desc_index,
				spc: {8'd0, item.sample_count}};
			upd.chunk_number  = chunk_inc;
			upd.entry_samples = {8'd0, item.sample_count};
			used_next         = kept + CW'(1);
			wr_addr           = kept[AW-1:0];
		end
	end

endmodule

>>> design/sample_to_chunk_table_builder.sv
`timescale 1ns / 1ps
// channel  | handshake                  | payload
// item     | item_valid / item_stall    | item   (stcb_pkg::item_t)
// result   | result_valid / result_stall| result (stcb_pkg::result_t)
// config   | cfg_wr_en                  | cfg_wr_data (16 bit)
// per word, the last two entries are first read from the entry memory,
// then the entry is updated and the output register loaded.
// a word is taken while a result still waits; the update cycle holds
// while the output register is full and stalled.
// arst_n clears counters and control; the entry memory is not cleared.

module sample_to_chunk_table_builder #(
	parameter int TABLE_DEPTH = stcb_pkg::TABLE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  stcb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output stcb_pkg::result_t result,
	input  logic              cfg_wr_en,
	input  logic [15:0]       cfg_wr_data
);
	import stcb_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	fsm_t          state_q;
	fsm_t          state_nxt;
	item_t         item_q;
	logic [15:0]   max_q;
	logic [CW-1:0] used_q;
	logic [23:0]   chunks_q;
	result_t       result_q;
	logic          result_valid_q;

	logic          accept;
	logic          commit;
	logic          out_free;
	entry_t        last;
	entry_t        prev;
	upd_t          upd;
	logic [CW-1:0] used_next;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] used_m1;
	logic [CW-1:0] used_m2;

	assign out_free = !result_valid_q || !result_stall;
	assign accept   = item_valid && !item_stall;
	assign used_m1  = used_q - CW'(1);
	assign used_m2  = used_q - CW'(2);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					state_nxt = FSM_CALC;
				end
			end
			FSM_CALC: begin
				if (out_free) begin
					state_nxt = FSM_IDLE;
				end
			end
			default: state_nxt = FSM_IDLE;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		commit     = 1'b0;
		case (state_q)
			FSM_IDLE: item_stall = 1'b0;
			FSM_CALC: commit = out_free;
			default: begin
				item_stall = 1'b1;
				commit     = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= FSM_IDLE;
			max_q          <= '0;
			used_q         <= '0;
			chunks_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (commit) begin
				used_q         <= used_next;
				chunks_q       <= upd.chunk_number;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (commit) begin
			result_q.status        <= upd.status;
			result_q.chunk_offset  <= upd.new_chunk ? item_q.byte_offset : 48'd0;
			result_q.chunk_number  <= upd.chunk_number;
			result_q.entry_count   <= 9'(used_next);
			result_q.entry_samples <= upd.entry_samples;
		end
	end

	stcb_entry_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk       (clk),
		.wr_en     (commit && upd.wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (upd.wr_entry),
		.rd_en     (accept),
		.rd_addr_a (used_m1[AW-1:0]),
		.rd_addr_b (used_m2[AW-1:0]),
		.rd_data_a (last),
		.rd_data_b (prev)
	);

	stcb_update #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_update (
		.item      (item_q),
		.max_spc   (max_q),
		.used      (used_q),
		.chunks    (chunks_q),
		.last      (last),
		.prev      (prev),
		.upd       (upd),
		.used_next (used_next),
		.wr_addr   (wr_addr)
	);

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> design/stcb_checker.sv
`timescale 1ns / 1ps

module stcb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input stcb_pkg::result_t result
);
	import stcb_pkg::*;

	// no offset unless a chunk was opened
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_APPEND || result.status == ST_FULL)
		|-> result.chunk_offset == 48'd0)
		else $error("chunk offset set without a new chunk");

	// a new chunk leaves a nonempty table and a nonzero chunk number
	a_new_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_NEW || result.status == ST_MERGE)
		|-> result.entry_count != 9'd0 && result.chunk_number != 24'd0)
		else $error("new chunk with empty table or zero chunk number");

	// empty table reports no samples, no chunk and status ST_FULL
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.entry_count == 9'd0
		|-> result.entry_samples == 24'd0 && result.chunk_number == 24'd0
			&& result.status == ST_FULL)
		else $error("empty table with nonzero fields");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result word changed");

endmodule

bind sample_to_chunk_table_builder stcb_checker u_stcb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
